### rtl/swem_pkg.sv
// Package: types, sizes and codes for the extract-max record stack.
`timescale 1ns / 1ps

package swem_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_PUSH = 2'd0,
    KIND_POP  = 2'd1,
    KIND_MAX  = 2'd2
  } kind_e_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_RESP
  } state_t;

  typedef struct packed {
    kind_e_t     kind;
    logic [15:0] proc_id;
    logic [15:0] wait_time;
  } in_item_t;

  typedef struct packed {
    status_e_t        status;
    logic [15:0]      out_id;
    logic [15:0]      out_wait;
    logic [CNT_W-1:0] count_after;
  } out_item_t;

  typedef struct packed {
    logic [15:0] proc_id;
    logic [15:0] wait_time;
  } rec_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

### rtl/stack_with_extract_max_wait.sv
// Top level: bounded record stack with pop-top and extract-max-wait.
//
// Input channel (in_valid/in_ready/in_item) takes one operation per transfer:
// push a record, pop the top record, or remove the record with the greatest
// wait time (ties go to the record nearest the top). Each operation gives
// exactly one result on the output channel (out_valid/out_ready/out_item)
// with a status, the removed record (zero when none) and the count left.
// Records sit in a row of cells, bottom at cell 0; a removal shifts every
// cell above the removed one down by one, all together in the shift state.
// Sequence: push, refused push, unused codes and an empty pop or extract-max
// go from idle straight to the response state; pop passes the shift state
// first; extract-max scans from the top down, one cell per cycle, then
// shifts; the result lands on out_valid at the edge that returns it to idle.
// A finished result waits in the output register while the next operation
// is accepted and worked on; when the receiver stalls, that next result is
// held internally and in_ready stays low until the output register frees.
// Reset (rst, synchronous) empties the stack and drops out_valid.
`timescale 1ns / 1ps

module stack_with_extract_max_wait (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  swem_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output swem_pkg::out_item_t out_item
);

  swem_pkg::rec_t      cell_recs [swem_pkg::DEPTH];
  swem_pkg::cell_ctl_t cell_ctl  [swem_pkg::DEPTH];
  swem_pkg::rec_t      push_rec;

  assign push_rec.proc_id   = in_item.proc_id;
  assign push_rec.wait_time = in_item.wait_time;

  swem_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cell_recs (cell_recs),
    .cell_ctl  (cell_ctl)
  );

  for (genvar i = 0; i < swem_pkg::DEPTH; i++) begin : g_cell
    swem_pkg::rec_t shift_in;
    if (i == swem_pkg::DEPTH - 1) begin : g_top
      assign shift_in = cell_recs[i];
    end else begin : g_mid
      assign shift_in = cell_recs[i + 1];
    end
    swem_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl[i]),
      .load_rec (push_rec),
      .shift_in (shift_in),
      .rec      (cell_recs[i])
    );
  end

endmodule

### rtl/swem_cell.sv
// One stack slot: loads a pushed record or takes its upper neighbor's record.
`timescale 1ns / 1ps

module swem_cell (
  input  logic               clk,
  input  swem_pkg::cell_ctl_t ctl,
  input  swem_pkg::rec_t     load_rec,
  input  swem_pkg::rec_t     shift_in,
  output swem_pkg::rec_t     rec
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rec <= load_rec;
    end else if (ctl.shift) begin
      rec <= shift_in;
    end
  end

endmodule

### rtl/swem_ctrl.sv
// Controller: fill count, max-wait scan, removal shift and result register.
`timescale 1ns / 1ps

module swem_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  swem_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output swem_pkg::out_item_t out_item,
  input  swem_pkg::rec_t      cell_recs [swem_pkg::DEPTH],
  output swem_pkg::cell_ctl_t cell_ctl  [swem_pkg::DEPTH]
);

  swem_pkg::state_t                state, state_next;
  logic [swem_pkg::CNT_W-1:0]      count, count_next;
  logic [swem_pkg::IDX_W-1:0]      idx, idx_next;
  logic [swem_pkg::IDX_W-1:0]      pick, pick_next;
  logic [15:0]                     best, best_next;
  swem_pkg::out_item_t             res, res_next;

  logic                            accept;
  logic                            empty;
  logic                            full;
  logic                            out_free;
  logic                            resp_fire;
  logic [swem_pkg::CNT_W-1:0]      cnt_m1;
  logic [swem_pkg::IDX_W-1:0]      top_idx;
  logic [swem_pkg::IDX_W-1:0]      push_idx;
  logic [swem_pkg::IDX_W-1:0]      idx_m1;
  swem_pkg::rec_t                  cand;
  swem_pkg::rec_t                  sel;

  assign accept    = in_valid && in_ready;
  assign empty     = (count == '0);
  assign full      = (count >= swem_pkg::CNT_W'(swem_pkg::DEPTH));
  assign out_free  = !out_valid || out_ready;
  assign resp_fire = (state == swem_pkg::ST_RESP) && out_free;
  assign cnt_m1    = count - swem_pkg::CNT_W'(1);
  assign top_idx   = cnt_m1[swem_pkg::IDX_W-1:0];
  assign push_idx  = count[swem_pkg::IDX_W-1:0];
  assign idx_m1    = idx - swem_pkg::IDX_W'(1);
  assign cand      = cell_recs[idx_m1];
  assign sel       = cell_recs[pick];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      swem_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_item.kind)
            swem_pkg::KIND_POP: begin
              state_next = empty ? swem_pkg::ST_RESP : swem_pkg::ST_SHIFT;
            end
            swem_pkg::KIND_MAX: begin
              if (empty) begin
                state_next = swem_pkg::ST_RESP;
              end else if (count == swem_pkg::CNT_W'(1)) begin
                state_next = swem_pkg::ST_SHIFT;
              end else begin
                state_next = swem_pkg::ST_SCAN;
              end
            end
            default: state_next = swem_pkg::ST_RESP;
          endcase
        end
      end
      swem_pkg::ST_SCAN: begin
        if (idx_m1 == '0) begin
          state_next = swem_pkg::ST_SHIFT;
        end
      end
      swem_pkg::ST_SHIFT: state_next = swem_pkg::ST_RESP;
      swem_pkg::ST_RESP: begin
        if (out_free) begin
          state_next = swem_pkg::ST_IDLE;
        end
      end
      default: state_next = swem_pkg::ST_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    count_next = count;
    idx_next   = idx;
    pick_next  = pick;
    best_next  = best;
    res_next   = res;
    unique case (state)
      swem_pkg::ST_IDLE: begin
        if (accept) begin
          res_next.status      = swem_pkg::STAT_OK;
          res_next.out_id      = '0;
          res_next.out_wait    = '0;
          res_next.count_after = count;
          case (in_item.kind)
            swem_pkg::KIND_PUSH: begin
              if (full) begin
                res_next.status = swem_pkg::STAT_FULL;
              end else begin
                count_next           = count + swem_pkg::CNT_W'(1);
                res_next.count_after = count + swem_pkg::CNT_W'(1);
              end
            end
            swem_pkg::KIND_POP, swem_pkg::KIND_MAX: begin
              if (empty) begin
                res_next.status = swem_pkg::STAT_EMPTY;
              end else begin
                pick_next = top_idx;
                idx_next  = top_idx;
                best_next = cell_recs[top_idx].wait_time;
              end
            end
            default: ;
          endcase
        end
      end
      swem_pkg::ST_SCAN: begin
        idx_next = idx_m1;
        // strict compare keeps the entry nearest the top on a tie
        if (cand.wait_time > best) begin
          best_next = cand.wait_time;
          pick_next = idx_m1;
        end
      end
      swem_pkg::ST_SHIFT: begin
        res_next.status      = swem_pkg::STAT_OK;
        res_next.out_id      = sel.proc_id;
        res_next.out_wait    = sel.wait_time;
        res_next.count_after = cnt_m1;
        count_next           = cnt_m1;
      end
      swem_pkg::ST_RESP: ;
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = (state == swem_pkg::ST_IDLE);
    for (int i = 0; i < swem_pkg::DEPTH; i++) begin
      cell_ctl[i].load  = accept && (in_item.kind == swem_pkg::KIND_PUSH) && !full &&
                          (push_idx == swem_pkg::IDX_W'(i));
      cell_ctl[i].shift = (state == swem_pkg::ST_SHIFT) &&
                          (swem_pkg::IDX_W'(i) >= pick);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= swem_pkg::ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= (out_valid && !out_ready) || resp_fire;
    end
  end

  always_ff @(posedge clk) begin
    idx  <= idx_next;
    pick <= pick_next;
    best <= best_next;
    res  <= res_next;
    if (resp_fire) begin
      out_item <= res;
    end
  end

endmodule

### rtl/swem_checker.sv
// Port-level checks for the record stack, bound to the top level.
`timescale 1ns / 1ps

module swem_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input swem_pkg::out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed or dropped while stalled");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status == swem_pkg::STAT_FULL) |->
      out_item.count_after == swem_pkg::CNT_W'(swem_pkg::DEPTH))
    else $error("full status with stack not full");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status == swem_pkg::STAT_EMPTY) |->
      (out_item.count_after == '0) && (out_item.out_id == '0) &&
      (out_item.out_wait == '0))
    else $error("empty status with nonzero fields");

  // in_ready is low in the cycle after every accepted operation
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready again right after a transfer");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result presented right after reset");

endmodule

bind stack_with_extract_max_wait swem_checker u_swem_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
